FILE: src/button_gesture_detector_defines.svh
// ----------------------------------------------------------------------------
// button gesture detector assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef BUTTON_GESTURE_DETECTOR_DEFINES_SVH
`define BUTTON_GESTURE_DETECTOR_DEFINES_SVH

// same-cycle implication
`define BGD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BGD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bgd_pkg.sv
// ----------------------------------------------------------------------------
// bgd_pkg
// shared types, constants and preset tables of the button gesture detector
// ----------------------------------------------------------------------------
package bgd_pkg;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
  localparam logic [CFG_W-1:0] DOUBLE_TAP_RST = 16'd300;

  localparam logic [2:0] BRIGHT_IDX_RST = 3'd0;
  localparam logic [2:0] FOAM_IDX_RST   = 3'd2;
  localparam logic [2:0] BRIGHT_LAST    = 3'd6;
  localparam logic [2:0] FOAM_LAST      = 3'd4;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE   = 2'd0,
    REG_LONG_PRESS = 2'd1,
    REG_DOUBLE_TAP = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic stable;
    logic pressed_edge;
    logic released_edge;
  } deb_t;

  function automatic logic [3:0] bright_value(logic [2:0] idx);
    logic [3:0] v;
    case (idx)
      3'd0:    v = 4'd3;
      3'd1:    v = 4'd4;
      3'd2:    v = 4'd5;
      3'd3:    v = 4'd6;
      3'd4:    v = 4'd9;
      3'd5:    v = 4'd11;
      3'd6:    v = 4'd13;
      default: v = 4'd3;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] foam_value(logic [2:0] idx);
    logic [4:0] v;
    case (idx)
      3'd0:    v = 5'd30;
      3'd1:    v = 5'd5;
      3'd2:    v = 5'd4;
      3'd3:    v = 5'd3;
      3'd4:    v = 5'd2;
      3'd5:    v = 5'd30;
      3'd6:    v = 5'd5;
      default: v = 5'd4;
    endcase
    return v;
  endfunction

endpackage

FILE: src/bgd_if.sv
// ----------------------------------------------------------------------------
// bgd channel interfaces
// valid/ready channels for tick input, result output and register writes
// ----------------------------------------------------------------------------
interface bgd_in_if;
  logic valid;
  logic ready;
  logic pin_level;

  modport source (output valid, output pin_level, input ready);
  modport sink   (input valid, input pin_level, output ready);
endinterface

interface bgd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture_event;
  logic       button_held;
  logic [4:0] color_number;
  logic [3:0] brightness_level;
  logic [4:0] foam_threshold;

  modport source (output valid, output gesture_event, output button_held,
                  output color_number, output brightness_level,
                  output foam_threshold, input ready);
  modport sink   (input valid, input gesture_event, input button_held,
                  input color_number, input brightness_level,
                  input foam_threshold, output ready);
endinterface

interface bgd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bgd_pkg::CFG_IDX_W-1:0]  index;
  logic [bgd_pkg::CFG_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/bgd_debounce.sv
// ----------------------------------------------------------------------------
// bgd_debounce
// raw level change counter, stable level and stable edge detection
// ----------------------------------------------------------------------------
module bgd_debounce #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  logic                       pin_level_i,
  input  logic [bgd_pkg::CFG_W-1:0]  debounce_ticks_i,
  output bgd_pkg::deb_t              deb_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > bgd_pkg::CFG_W) ? TIMER_BITS : bgd_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

  logic                  last_raw_q, last_raw_d;
  logic                  stable_q, stable_d;
  logic [TIMER_BITS-1:0] since_q, since_d;
  logic                  raw;

  assign raw = ~pin_level_i;

  always_comb begin
    last_raw_d = raw;
    if (raw != last_raw_q) begin
      since_d = '0;
    end else if (since_q == TMAX) begin
      since_d = since_q;
    end else begin
      since_d = since_q + 1'b1;
    end
    if (CMP_W'(since_d) > CMP_W'(debounce_ticks_i)) begin
      stable_d = raw;
    end else begin
      stable_d = stable_q;
    end
  end

  assign deb_o.stable        = stable_d;
  assign deb_o.pressed_edge  = stable_d & ~stable_q;
  assign deb_o.released_edge = ~stable_d & stable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q   <= 1'b0;
      since_q    <= '0;
    end else if (accept_i) begin
      last_raw_q <= last_raw_d;
      stable_q   <= stable_d;
      since_q    <= since_d;
    end
  end

endmodule

FILE: src/bgd_gesture.sv
// ----------------------------------------------------------------------------
// bgd_gesture
// gesture state machine, hold and release timers, preset index updates
// ----------------------------------------------------------------------------
`include "button_gesture_detector_defines.svh"

module bgd_gesture #(
  parameter int unsigned COLOR_COUNT = 17,
  parameter int unsigned TIMER_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       accept_i,
  input  bgd_pkg::deb_t              deb_i,
  input  logic [bgd_pkg::CFG_W-1:0]  long_press_ticks_i,
  input  logic [bgd_pkg::CFG_W-1:0]  double_tap_ticks_i,
  output bgd_pkg::event_e            event_o,
  output logic [4:0]                 color_o,
  output logic [3:0]                 bright_o,
  output logic [4:0]                 foam_o
);

  localparam int unsigned CMP_W = (TIMER_BITS > bgd_pkg::CFG_W) ? TIMER_BITS : bgd_pkg::CFG_W;
  localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
  localparam logic [4:0] COLOR_LAST = 5'(COLOR_COUNT - 1);

  typedef enum logic [4:0] {
    ST_IDLE          = 5'b00001,
    ST_PRESSED       = 5'b00010,
    ST_RELEASED_ONCE = 5'b00100,
    ST_LONG_ACTIVE   = 5'b01000,
    ST_WAIT_RELEASE  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [TIMER_BITS-1:0] hold_q, hold_d, hold_inc;
  logic [TIMER_BITS-1:0] rel_q, rel_d, rel_inc;
  logic [4:0]            color_q, color_d;
  logic [2:0]            bright_q, bright_d;
  logic [2:0]            foam_q, foam_d;
  bgd_pkg::event_e       ev_d;

  assign hold_inc = (hold_q == TMAX) ? hold_q : hold_q + 1'b1;
  assign rel_inc  = (rel_q == TMAX) ? rel_q : rel_q + 1'b1;

  always_comb begin
    state_d  = state_q;
    hold_d   = hold_q;
    rel_d    = rel_q;
    color_d  = color_q;
    bright_d = bright_q;
    foam_d   = foam_q;
    ev_d     = bgd_pkg::EV_NONE;
    case (state_q)
      ST_PRESSED: begin
        hold_d = hold_inc;
        if (deb_i.released_edge) begin
          state_d = ST_RELEASED_ONCE;
          rel_d   = '0;
        end else if (deb_i.stable &&
                     (CMP_W'(hold_inc) >= CMP_W'(long_press_ticks_i))) begin
          state_d = ST_LONG_ACTIVE;
          foam_d  = (foam_q >= bgd_pkg::FOAM_LAST) ? 3'd0 : foam_q + 3'd1;
          ev_d    = bgd_pkg::EV_LONG;
        end
      end
      ST_RELEASED_ONCE: begin
        rel_d = rel_inc;
        if (deb_i.pressed_edge) begin
          color_d = (color_q >= COLOR_LAST) ? 5'd0 : color_q + 5'd1;
          state_d = ST_WAIT_RELEASE;
          ev_d    = bgd_pkg::EV_DOUBLE;
        end else if (CMP_W'(rel_inc) > CMP_W'(double_tap_ticks_i)) begin
          bright_d = (bright_q >= bgd_pkg::BRIGHT_LAST) ? 3'd0 : bright_q + 3'd1;
          state_d  = ST_IDLE;
          ev_d     = bgd_pkg::EV_SINGLE;
        end
      end
      ST_LONG_ACTIVE, ST_WAIT_RELEASE: begin
        if (deb_i.released_edge) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        if (deb_i.pressed_edge) begin
          state_d = ST_PRESSED;
          hold_d  = '0;
        end
      end
    endcase
  end

  assign event_o  = ev_d;
  assign color_o  = color_d;
  assign bright_o = bgd_pkg::bright_value(bright_d);
  assign foam_o   = bgd_pkg::foam_value(foam_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hold_q   <= '0;
      rel_q    <= '0;
      color_q  <= 5'd0;
      bright_q <= bgd_pkg::BRIGHT_IDX_RST;
      foam_q   <= bgd_pkg::FOAM_IDX_RST;
    end else if (accept_i) begin
      state_q  <= state_d;
      hold_q   <= hold_d;
      rel_q    <= rel_d;
      color_q  <= color_d;
      bright_q <= bright_d;
      foam_q   <= foam_d;
    end
  end

  `BGD_ASSERT_NEXT(a_long_enters_active, accept_i && ev_d == bgd_pkg::EV_LONG,
                   state_q == ST_LONG_ACTIVE, "long press did not enter long active")
  `BGD_ASSERT_NOW(a_double_from_released, accept_i && ev_d == bgd_pkg::EV_DOUBLE,
                  state_q == ST_RELEASED_ONCE, "double tap outside released state")
  `BGD_ASSERT_NOW(a_color_in_range, 1'b1, int'(color_q) < COLOR_COUNT,
                  "color index out of range")
  `BGD_ASSERT_NEXT(a_idle_holds_presets, !accept_i,
                   $stable(color_q) && $stable(bright_q) && $stable(foam_q),
                   "presets changed without a transfer")

endmodule

FILE: src/button_gesture_detector.sv
// ----------------------------------------------------------------------------
// button_gesture_detector
// debounced single tap, double tap and long press detector with presets
// ----------------------------------------------------------------------------
// One tick is taken per clock cycle and yields one result, which appears in
// the output register on the cycle after the tick transfer. The tick input
// stays ready while the output register is empty or being drained, so with a
// sink that is always ready the block sustains one tick per cycle; the single
// output register sets that figure. Register writes are always ready.
module button_gesture_detector #(
  parameter int unsigned COLOR_COUNT = 17,
  parameter int unsigned TIMER_BITS  = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  bgd_in_if.sink     in_i,
  bgd_out_if.source  out_o,
  bgd_cfg_if.sink    cfg_i
);

  logic [bgd_pkg::CFG_W-1:0] debounce_q, long_press_q, double_tap_q;
  logic                      out_valid_q;
  logic [1:0]                event_q;
  logic                      held_q;
  logic [4:0]                color_q;
  logic [3:0]                bright_q;
  logic [4:0]                foam_q;

  logic            accept;
  bgd_pkg::deb_t   deb;
  bgd_pkg::event_e ev;
  logic [4:0]      color;
  logic [3:0]      bright;
  logic [4:0]      foam;

  assign in_i.ready  = ~out_valid_q | out_o.ready;
  assign accept      = in_i.valid & in_i.ready;
  assign cfg_i.ready = 1'b1;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q   <= bgd_pkg::DEBOUNCE_RST;
      long_press_q <= bgd_pkg::LONG_PRESS_RST;
      double_tap_q <= bgd_pkg::DOUBLE_TAP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        bgd_pkg::REG_DEBOUNCE:   debounce_q   <= cfg_i.data;
        bgd_pkg::REG_LONG_PRESS: long_press_q <= cfg_i.data;
        bgd_pkg::REG_DOUBLE_TAP: double_tap_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  bgd_debounce #(
    .TIMER_BITS (TIMER_BITS)
  ) u_debounce (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .pin_level_i      (in_i.pin_level),
    .debounce_ticks_i (debounce_q),
    .deb_o            (deb)
  );

  bgd_gesture #(
    .COLOR_COUNT (COLOR_COUNT),
    .TIMER_BITS  (TIMER_BITS)
  ) u_gesture (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .deb_i              (deb),
    .long_press_ticks_i (long_press_q),
    .double_tap_ticks_i (double_tap_q),
    .event_o            (ev),
    .color_o            (color),
    .bright_o           (bright),
    .foam_o             (foam)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      event_q  <= ev;
      held_q   <= deb.stable;
      color_q  <= color;
      bright_q <= bright;
      foam_q   <= foam;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.gesture_event    = event_q;
  assign out_o.button_held      = held_q;
  assign out_o.color_number     = color_q;
  assign out_o.brightness_level = bright_q;
  assign out_o.foam_threshold   = foam_q;

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// checks the button gesture detector tick by tick: a table of hand-worked
// taps, double taps and long presses, then random press and release patterns
// with contact bounce under several timing settings, and finally near-widest
// timing settings with short holds. every result transfer is compared field
// by field with the hand-worked value or an in-bench model of the gesture
// machine, while sender gaps and sink stalls vary across the run
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned COLOR_COUNT  = 17;
  localparam int unsigned TIMER_BITS   = 16;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned EXTREME_HOLD = 12;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 70;

  localparam logic [bgd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam logic [bgd_pkg::CFG_W-1:0]     CFG_MAX   = 16'd65534;

  typedef enum logic [4:0] {
    G_IDLE          = 5'b00001,
    G_PRESSED       = 5'b00010,
    G_RELEASED_ONCE = 5'b00100,
    G_LONG_ACTIVE   = 5'b01000,
    G_WAIT_RELEASE  = 5'b10000
  } gesture_state_e;

  typedef enum logic {
    ROW_TICK,
    ROW_REG
  } row_kind_e;

  typedef struct packed {
    bgd_pkg::event_e ev;
    logic            held;
    logic [4:0]      color;
    logic [3:0]      bright;
    logic [4:0]      foam;
  } gesture_result_t;

  typedef struct packed {
    row_kind_e                     kind;
    logic                          pin;
    logic [bgd_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [bgd_pkg::CFG_W-1:0]     reg_data;
    logic                          typed;
    gesture_result_t               want;
  } directed_row_t;

  localparam gesture_result_t NO_RESULT = '0;

  localparam logic [3:0] BRIGHT_STEPS [7] = '{4'd3, 4'd4, 4'd5, 4'd6, 4'd9, 4'd11, 4'd13};
  localparam logic [4:0] FOAM_STEPS   [5] = '{5'd30, 5'd5, 5'd4, 5'd3, 5'd2};

  // debounce 0, long press 3, double tap window 1
  localparam directed_row_t DIRECTED [26] = '{
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b1,
      '{bgd_pkg::EV_NONE, 1'b0, 5'd0, 4'd3, 5'd4}},
    '{ROW_REG, 1'b1, REG_SPARE, 16'hffff, 1'b0, NO_RESULT},
    '{ROW_REG, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_REG, 1'b1, bgd_pkg::REG_LONG_PRESS, 16'd3, 1'b0, NO_RESULT},
    '{ROW_REG, 1'b1, bgd_pkg::REG_DOUBLE_TAP, 16'd1, 1'b0, NO_RESULT},
    // single tap
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b1,
      '{bgd_pkg::EV_SINGLE, 1'b0, 5'd0, 4'd4, 5'd4}},
    // double tap, second press lands on the window timeout tick
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b1,
      '{bgd_pkg::EV_DOUBLE, 1'b1, 5'd1, 4'd4, 5'd4}},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    // long press
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b0, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b1,
      '{bgd_pkg::EV_LONG, 1'b1, 5'd1, 4'd4, 5'd3}},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT},
    '{ROW_TICK, 1'b1, bgd_pkg::REG_DEBOUNCE, 16'd0, 1'b0, NO_RESULT}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  logic                          tick_valid = 1'b0;
  logic                          tick_pin   = 1'b1;
  logic                          sink_ready = 1'b0;
  logic                          reg_valid  = 1'b0;
  logic [bgd_pkg::CFG_IDX_W-1:0] reg_idx    = bgd_pkg::REG_DEBOUNCE;
  logic [bgd_pkg::CFG_W-1:0]     reg_data   = '0;

  bgd_in_if  tick_ch ();
  bgd_out_if res_ch ();
  bgd_cfg_if reg_ch ();

  assign tick_ch.valid     = tick_valid;
  assign tick_ch.pin_level = tick_pin;
  assign res_ch.ready      = sink_ready;
  assign reg_ch.valid      = reg_valid;
  assign reg_ch.index      = reg_idx;
  assign reg_ch.data       = reg_data;

  button_gesture_detector #(
    .COLOR_COUNT (COLOR_COUNT),
    .TIMER_BITS  (TIMER_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (tick_ch),
    .out_o  (res_ch),
    .cfg_i  (reg_ch)
  );

  // gesture model state
  logic [bgd_pkg::CFG_W-1:0] deb_cfg        = bgd_pkg::DEBOUNCE_RST;
  logic [bgd_pkg::CFG_W-1:0] long_cfg       = bgd_pkg::LONG_PRESS_RST;
  logic [bgd_pkg::CFG_W-1:0] dbl_cfg        = bgd_pkg::DOUBLE_TAP_RST;
  gesture_state_e            g_state        = G_IDLE;
  logic                      raw_last       = 1'b0;
  logic                      stable_now     = 1'b0;
  logic                      stable_prev    = 1'b0;
  logic [TIMER_BITS-1:0]     since_change   = '0;
  logic [TIMER_BITS-1:0]     held_ticks     = '0;
  logic [TIMER_BITS-1:0]     released_ticks = '0;
  logic [4:0]                color_idx      = '0;
  logic [2:0]                bright_idx     = bgd_pkg::BRIGHT_IDX_RST;
  logic [2:0]                foam_idx       = bgd_pkg::FOAM_IDX_RST;

  gesture_result_t expected_results [$];
  gesture_result_t want_now;
  int unsigned     mismatch_count = 0;
  int unsigned     items_sent     = 0;
  int unsigned     cycle_count    = 0;
  int unsigned     tick_gap_pct   = 0;
  int unsigned     sink_stall_pct = 0;
  bit              tick_live      = 1'b0;
  bit              reg_live       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [TIMER_BITS-1:0] bump(input logic [TIMER_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  function automatic gesture_result_t step_gesture(input logic pin);
    gesture_result_t r;
    logic            raw_pressed;
    logic            press_edge;
    logic            release_edge;
    bgd_pkg::event_e ev;
    raw_pressed = ~pin;
    ev = bgd_pkg::EV_NONE;
    if (raw_pressed != raw_last) since_change = '0;
    else since_change = bump(since_change);
    raw_last = raw_pressed;
    if (since_change > deb_cfg) stable_now = raw_pressed;
    press_edge   = stable_now & ~stable_prev;
    release_edge = ~stable_now & stable_prev;
    stable_prev  = stable_now;
    case (g_state)
      G_PRESSED: begin
        held_ticks = bump(held_ticks);
        if (release_edge) begin
          g_state = G_RELEASED_ONCE;
          released_ticks = '0;
        end else if (stable_now && held_ticks >= long_cfg) begin
          g_state = G_LONG_ACTIVE;
          foam_idx = (foam_idx == bgd_pkg::FOAM_LAST) ? '0 : foam_idx + 1'b1;
          ev = bgd_pkg::EV_LONG;
        end
      end
      G_RELEASED_ONCE: begin
        released_ticks = bump(released_ticks);
        // a press edge beats a window timeout on the same tick
        if (press_edge) begin
          color_idx = (color_idx == COLOR_COUNT - 1) ? '0 : color_idx + 1'b1;
          g_state = G_WAIT_RELEASE;
          ev = bgd_pkg::EV_DOUBLE;
        end else if (released_ticks > dbl_cfg) begin
          bright_idx = (bright_idx == bgd_pkg::BRIGHT_LAST) ? '0 : bright_idx + 1'b1;
          g_state = G_IDLE;
          ev = bgd_pkg::EV_SINGLE;
        end
      end
      G_LONG_ACTIVE, G_WAIT_RELEASE: begin
        if (release_edge) g_state = G_IDLE;
      end
      default: begin
        g_state = G_IDLE;
        if (press_edge) begin
          g_state = G_PRESSED;
          held_ticks = '0;
        end
      end
    endcase
    r.ev     = ev;
    r.held   = stable_now;
    r.color  = color_idx;
    r.bright = BRIGHT_STEPS[bright_idx];
    r.foam   = FOAM_STEPS[foam_idx];
    return r;
  endfunction

  task automatic send_tick(input logic pin, input logic typed, input gesture_result_t want);
    gesture_result_t model;
    tick_valid <= 1'b1;
    tick_pin   <= pin;
    tick_live   = 1'b1;
    do @(posedge clk_i); while (!tick_ch.ready);
    model = step_gesture(pin);
    expected_results.push_back(typed ? want : model);
    items_sent++;
    if ($urandom_range(99) < tick_gap_pct) begin
      tick_valid <= 1'b0;
      tick_live   = 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tick_gap_pct);
    end
  endtask

  task automatic wait_drained();
    if (tick_live) begin
      tick_valid <= 1'b0;
      tick_live   = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [bgd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bgd_pkg::CFG_W-1:0] data);
    reg_valid <= 1'b1;
    reg_idx   <= idx;
    reg_data  <= data;
    reg_live   = 1'b1;
    do @(posedge clk_i); while (!reg_ch.ready);
    case (idx)
      bgd_pkg::REG_DEBOUNCE:   deb_cfg  = data;
      bgd_pkg::REG_LONG_PRESS: long_cfg = data;
      bgd_pkg::REG_DOUBLE_TAP: dbl_cfg  = data;
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [bgd_pkg::CFG_W-1:0] deb,
                             input logic [bgd_pkg::CFG_W-1:0] lng,
                             input logic [bgd_pkg::CFG_W-1:0] dbl);
    wait_drained();
    write_reg(bgd_pkg::REG_DEBOUNCE, deb);
    write_reg(bgd_pkg::REG_LONG_PRESS, lng);
    write_reg(bgd_pkg::REG_DOUBLE_TAP, dbl);
    reg_valid <= 1'b0;
    reg_live   = 1'b0;
  endtask

  task automatic hold_level(input logic pin, input int unsigned ticks);
    repeat (ticks) send_tick(pin, 1'b0, NO_RESULT);
  endtask

  // contact bounce: glitches short enough to stay under the debounce time
  task automatic chatter(input logic pin);
    repeat ($urandom_range(0, 2)) begin
      hold_level(pin, $urandom_range(1, deb_cfg + 1));
      hold_level(~pin, $urandom_range(1, deb_cfg + 1));
    end
  endtask

  task automatic press_release(input int unsigned press_ticks, input int unsigned release_ticks);
    if ($urandom_range(99) < 30) chatter(1'b0);
    hold_level(1'b0, press_ticks);
    if ($urandom_range(99) < 30) chatter(1'b1);
    hold_level(1'b1, release_ticks);
  endtask

  task automatic random_gestures(input int unsigned n);
    int unsigned stop_at;
    int unsigned settle;
    int unsigned pick;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      settle = deb_cfg + 2;
      pick   = $urandom_range(99);
      if (pick < 30) begin
        press_release(settle + $urandom_range(0, long_cfg),
                      settle + dbl_cfg + $urandom_range(1, 4));
      end else if (pick < 55) begin
        press_release(settle + $urandom_range(0, long_cfg), settle + $urandom_range(0, dbl_cfg));
        press_release(settle + $urandom_range(0, long_cfg),
                      settle + dbl_cfg + $urandom_range(1, 4));
      end else if (pick < 75) begin
        press_release(settle + long_cfg + $urandom_range(0, 6), settle + $urandom_range(0, 4));
      end else if (pick < 90) begin
        press_release($urandom_range(1, settle + long_cfg + 4),
                      $urandom_range(1, settle + dbl_cfg + 4));
      end else begin
        repeat ($urandom_range(1, 8)) send_tick(1'($urandom_range(0, 1)), 1'b0, NO_RESULT);
      end
    end
  endtask

  task automatic random_phases();
    load_config('0, '0, '0);
    random_gestures(PHASE_ITEMS);
    load_config($urandom_range(0, 2), $urandom_range(0, 8), $urandom_range(0, 6));
    random_gestures(PHASE_ITEMS);
    load_config($urandom_range(0, 6), $urandom_range(0, 24), $urandom_range(0, 16));
    random_gestures(PHASE_ITEMS);
  endtask

  always @(posedge clk_i) begin
    sink_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: ev=%0d held=%0d color=%0d bright=%0d foam=%0d",
                   res_ch.gesture_event, res_ch.button_held, res_ch.color_number,
                   res_ch.brightness_level, res_ch.foam_threshold);
      end else begin
        want_now = expected_results.pop_front();
        if (res_ch.gesture_event !== want_now.ev || res_ch.button_held !== want_now.held ||
            res_ch.color_number !== want_now.color ||
            res_ch.brightness_level !== want_now.bright ||
            res_ch.foam_threshold !== want_now.foam) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result mismatch at cycle %0d: expected ev=%0d held=%0d color=%0d",
                     cycle_count, want_now.ev, want_now.held, want_now.color);
            $display("  expected bright=%0d foam=%0d", want_now.bright, want_now.foam);
            $display("  got ev=%0d held=%0d color=%0d bright=%0d foam=%0d",
                     res_ch.gesture_event, res_ch.button_held, res_ch.color_number,
                     res_ch.brightness_level, res_ch.foam_threshold);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sender idles a little, sink stalls a lot
    tick_gap_pct   = 11;
    sink_stall_pct = 55;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_data);
      end else begin
        if (reg_live) begin
          reg_valid <= 1'b0;
          reg_live   = 1'b0;
        end
        send_tick(DIRECTED[i].pin, DIRECTED[i].typed, DIRECTED[i].want);
      end
    end
    random_phases();

    // sender idles a lot, sink stalls a little
    tick_gap_pct   = 55;
    sink_stall_pct = 11;
    random_phases();

    // back to back
    tick_gap_pct   = 0;
    sink_stall_pct = 0;
    random_phases();

    // near-widest debounce (CFG_MAX), short holds never settle
    load_config(CFG_MAX, '0, '0);
    hold_level(1'b0, EXTREME_HOLD);
    hold_level(1'b1, EXTREME_HOLD);

    // near-widest long press and double tap windows (CFG_MAX)
    load_config('0, CFG_MAX, CFG_MAX);
    hold_level(1'b0, EXTREME_HOLD);
    hold_level(1'b1, 3);
    hold_level(1'b0, 3);
    hold_level(1'b1, EXTREME_HOLD);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: button_gesture_detector.f
+incdir+src
src/bgd_pkg.sv
src/bgd_if.sv
src/bgd_debounce.sv
src/bgd_gesture.sv
src/button_gesture_detector.sv
verif/tb_top.sv
